// File: sv/oma_pkg.sv
// ----------------------------------------------------------------------------
// oma_pkg
// Shared widths, register indexes and controller/datapath signal groups of
// the outlier rejecting moving average.
// ----------------------------------------------------------------------------
`default_nettype none

package oma_pkg;

  // Field widths.
  localparam int SAMPLE_W   = 16;
  localparam int VALUE_W    = 24;
  localparam int FRAC_W     = 8;
  localparam int WLEN_W     = 6;
  localparam int ROUNDS_W   = 5;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTLIER_ROUNDS = 1'b1;

  // Register reset values.
  localparam logic [WLEN_W-1:0]   WLEN_RESET   = 6'd20;
  localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 5'd4;

  // What the datapath does with a word read from a memory.
  typedef enum logic [1:0] {
    OP_COPY,
    OP_SCAN,
    OP_SUM
  } dp_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic   accept;
    logic   rd;
    dp_op_e op;
    logic   repl_hi;
    logic   repl_lo;
    logic   rnd_inc;
    logic   div_start;
    logic   out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic idx_last;
    logic rounds_done;
    logic div_busy;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: sv/oma_sample_if.sv
// ----------------------------------------------------------------------------
// oma_sample_if
// Valid/ready channel that carries one signed input sample per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface oma_sample_if;

  logic                                valid;
  logic                                ready;
  logic signed [oma_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);

endinterface

`default_nettype wire

// File: sv/oma_result_if.sv
// ----------------------------------------------------------------------------
// oma_result_if
// Valid/ready channel that carries one filtered Q16.8 value per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface oma_result_if;

  logic                               valid;
  logic                               ready;
  logic signed [oma_pkg::VALUE_W-1:0] filtered_value;

  modport source (output valid, output filtered_value, input ready);
  modport sink (input valid, input filtered_value, output ready);

endinterface

`default_nettype wire

// File: sv/oma_div.sv
// ----------------------------------------------------------------------------
// oma_div
// Signed by unsigned restoring divider, one quotient bit per cycle, with the
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module oma_div #(
  parameter int DVD_W = 30,
  parameter int DVS_W = 6
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [DVD_W-1:0] dividend_i,
  input  wire logic        [DVS_W-1:0] divisor_i,
  output logic                         busy_o,
  output logic signed      [DVD_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             neg_q;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVD_W-1:0] mag;
  logic [DVS_W:0]   rem_shift;
  logic             take;
  logic [DVS_W:0]   rem_diff;

  // Magnitude of the dividend; the most negative value maps onto itself.
  assign mag = dividend_i[DVD_W-1] ? DVD_W'(-dividend_i) : dividend_i;

  // One restoring step: bring down the next bit and try a subtraction.
  assign rem_shift = {rem_q, quo_q[DVD_W-1]};
  assign take      = (rem_shift >= {1'b0, dvs_q});
  assign rem_diff  = rem_shift - {1'b0, dvs_q};

  // Iteration control.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DVD_W);
    end else if (busy_q) begin
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Shift register: dividend bits leave at the top, quotient bits enter below.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DVD_W-1];
      quo_q <= mag;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DVD_W-2:0], take};
      rem_q <= take ? rem_diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = neg_q ? DVD_W'(-quo_q) : quo_q;

endmodule

`default_nettype wire

// File: sv/oma_dp.sv
// ----------------------------------------------------------------------------
// oma_dp
// Datapath: configuration registers, sample ring, working copy of the window,
// max/min tracking, accumulator, divider and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module oma_dp #(
  parameter int MAX_WINDOW = 32
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic        [oma_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic        [oma_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic signed [oma_pkg::SAMPLE_W-1:0]   sample_i,
  input  wire oma_pkg::dp_cmd_t                      cmd_i,
  output oma_pkg::dp_sts_t                           sts_o,
  output logic signed      [oma_pkg::VALUE_W-1:0]    filtered_value_o
);

  import oma_pkg::*;

  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = VALUE_W + CNT_W;

  logic [WLEN_W-1:0]   wlen_q;
  logic [ROUNDS_W-1:0] rounds_q;
  logic [ROUNDS_W-1:0] rnd_q;
  logic [CNT_W-1:0]    n_len;

  logic [IDX_W-1:0]    wp_q, wp_d;
  logic [IDX_W-1:0]    wslot;
  logic [CNT_W-1:0]    wp_next;
  logic [IDX_W-1:0]    idx_q;
  logic                idx_last;

  logic [SAMPLE_W-1:0] ring_mem [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] ring_vld_q;
  logic [SAMPLE_W-1:0] ring_rd_q;
  logic                ring_rd_vld_q;
  logic signed [VALUE_W-1:0] ring_q8;

  logic [VALUE_W-1:0]        work_mem [MAX_WINDOW];
  logic signed [VALUE_W-1:0] work_rd_q;
  logic                      work_wr_en;
  logic [IDX_W-1:0]          work_wr_addr;
  logic [VALUE_W-1:0]        work_wr_data;

  logic              rd_vld_q;
  dp_op_e            rd_op_q;
  logic [IDX_W-1:0]  rd_idx_q;
  logic              rd_first_q;

  logic signed [VALUE_W-1:0] hi_val_q, lo_val_q;
  logic [IDX_W-1:0]          hi_idx_q, lo_idx_q;
  logic signed [SUM_W-1:0]   acc_q;
  logic signed [VALUE_W-1:0] last_q;

  logic                    div_busy;
  logic signed [SUM_W-1:0] quotient;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q   <= WLEN_RESET;
      rounds_q <= ROUNDS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WINDOW_LENGTH:  wlen_q   <= cfg_wdata_i[WLEN_W-1:0];
        CFG_OUTLIER_ROUNDS: rounds_q <= cfg_wdata_i[ROUNDS_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective window length: zero counts as one, large values saturate.
  always_comb begin
    if (wlen_q == '0) begin
      n_len = CNT_W'(1);
    end else if (int'(wlen_q) > MAX_WINDOW) begin
      n_len = CNT_W'(MAX_WINDOW);
    end else begin
      n_len = CNT_W'(wlen_q);
    end
  end

  // Write position: restart at slot zero when the window has shrunk.
  always_comb begin
    wslot   = (CNT_W'(wp_q) >= n_len) ? '0 : wp_q;
    wp_next = CNT_W'(wslot) + CNT_W'(1);
    wp_d    = (wp_next >= n_len) ? '0 : IDX_W'(wp_next);
  end

  assign idx_last = (CNT_W'(idx_q) == n_len - CNT_W'(1));

  // Position, sweep index, round counter and ring valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      idx_q      <= '0;
      rnd_q      <= '0;
      ring_vld_q <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd;
      if (cmd_i.accept) begin
        wp_q              <= wp_d;
        ring_vld_q[wslot] <= 1'b1;
      end
      if (cmd_i.rd) begin
        idx_q <= idx_last ? '0 : idx_q + IDX_W'(1);
      end
      if (cmd_i.accept) begin
        rnd_q <= '0;
      end else if (cmd_i.rnd_inc) begin
        rnd_q <= rnd_q + ROUNDS_W'(1);
      end
    end
  end

  // Sample ring: written on an accepted transaction, read during the copy.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ring_mem[wslot] <= sample_i;
    end
    if (cmd_i.rd) begin
      ring_rd_q     <= ring_mem[idx_q];
      ring_rd_vld_q <= ring_vld_q[idx_q];
    end
  end

  // A slot never written reads as zero; scale to Q16.8.
  assign ring_q8 = ring_rd_vld_q ? {ring_rd_q, FRAC_W'(0)} : '0;

  // Write port of the working copy.
  always_comb begin
    work_wr_en   = 1'b0;
    work_wr_addr = rd_idx_q;
    work_wr_data = ring_q8;
    if (rd_vld_q && (rd_op_q == OP_COPY)) begin
      work_wr_en = 1'b1;
    end else if (cmd_i.repl_hi) begin
      work_wr_en   = 1'b1;
      work_wr_addr = hi_idx_q;
      work_wr_data = last_q;
    end else if (cmd_i.repl_lo) begin
      work_wr_en   = 1'b1;
      work_wr_addr = lo_idx_q;
      work_wr_data = last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (work_wr_en) begin
      work_mem[work_wr_addr] <= work_wr_data;
    end
    if (cmd_i.rd) begin
      work_rd_q <= work_mem[idx_q];
    end
  end

  // Read pipeline tag: what to do with the word that arrives next cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_op_q    <= cmd_i.op;
      rd_idx_q   <= idx_q;
      rd_first_q <= (idx_q == '0);
    end
  end

  // Max/min search (last index on ties) and window sum.
  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      case (rd_op_q)
        OP_SCAN: begin
          if (rd_first_q) begin
            hi_val_q <= work_rd_q;
            hi_idx_q <= rd_idx_q;
            lo_val_q <= work_rd_q;
            lo_idx_q <= rd_idx_q;
          end else begin
            if (work_rd_q >= hi_val_q) begin
              hi_val_q <= work_rd_q;
              hi_idx_q <= rd_idx_q;
            end
            if (work_rd_q <= lo_val_q) begin
              lo_val_q <= work_rd_q;
              lo_idx_q <= rd_idx_q;
            end
          end
        end
        OP_SUM: begin
          acc_q <= rd_first_q ? SUM_W'(work_rd_q) : acc_q + SUM_W'(work_rd_q);
        end
        default: ;
      endcase
    end
  end

  // Division of the sum by the window length.
  oma_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (acc_q),
    .divisor_i  (n_len),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // Previous output, which also drives the result channel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (cmd_i.out_load) begin
      last_q <= quotient[VALUE_W-1:0];
    end
  end

  assign sts_o.idx_last    = idx_last;
  assign sts_o.rounds_done = (rnd_q == rounds_q);
  assign sts_o.div_busy    = div_busy;
  assign filtered_value_o  = last_q;

  // Outside the copy, a read of the working copy never meets a write to the same entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rd && (cmd_i.op != OP_COPY)) |-> !(work_wr_en && (work_wr_addr == idx_q)))
    else $error("working copy read collides with a write");

  // After a sample is stored the position lies inside the window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept |=> (CNT_W'(wp_q) < $past(n_len)))
    else $error("write position left the window");

endmodule

`default_nettype wire

// File: sv/oma_ctrl.sv
// ----------------------------------------------------------------------------
// oma_ctrl
// Controller: sequences copy, outlier rounds, summation and division for one
// sample, and owns the handshakes of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module oma_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output oma_pkg::dp_cmd_t      cmd_o,
  input  wire oma_pkg::dp_sts_t sts_i
);

  import oma_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_COPY    = 4'd1;
  localparam logic [3:0] S_COPY_W  = 4'd2;
  localparam logic [3:0] S_CHECK   = 4'd3;
  localparam logic [3:0] S_SCAN    = 4'd4;
  localparam logic [3:0] S_SCAN_W  = 4'd5;
  localparam logic [3:0] S_REPL_HI = 4'd6;
  localparam logic [3:0] S_REPL_LO = 4'd7;
  localparam logic [3:0] S_SUM     = 4'd8;
  localparam logic [3:0] S_SUM_W   = 4'd9;
  localparam logic [3:0] S_DIV     = 4'd10;
  localparam logic [3:0] S_DIV_W   = 4'd11;
  localparam logic [3:0] S_DONE    = 4'd12;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.op   = OP_COPY;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_COPY;
        end
      end
      S_COPY: begin
        cmd_o.rd = 1'b1;
        if (sts_i.idx_last) begin
          state_d = S_COPY_W;
        end
      end
      S_COPY_W: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        state_d = sts_i.rounds_done ? S_SUM : S_SCAN;
      end
      S_SCAN: begin
        cmd_o.rd = 1'b1;
        cmd_o.op = OP_SCAN;
        if (sts_i.idx_last) begin
          state_d = S_SCAN_W;
        end
      end
      S_SCAN_W: begin
        state_d = S_REPL_HI;
      end
      S_REPL_HI: begin
        cmd_o.repl_hi = 1'b1;
        state_d       = S_REPL_LO;
      end
      S_REPL_LO: begin
        cmd_o.repl_lo = 1'b1;
        cmd_o.rnd_inc = 1'b1;
        state_d       = S_CHECK;
      end
      S_SUM: begin
        cmd_o.rd = 1'b1;
        cmd_o.op = OP_SUM;
        if (sts_i.idx_last) begin
          state_d = S_SUM_W;
        end
      end
      S_SUM_W: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV_W;
      end
      S_DIV_W: begin
        if (!sts_i.div_busy) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid: set on a load, cleared when the transaction completes.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // The divider only runs while the controller waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_busy |-> (state_q == S_DIV_W))
    else $error("divider busy outside its wait state");

  // A new result appears only after a finished calculation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("result raised without a finished calculation");

  // A finished result waits while the output register is still occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) && out_valid_q && !out_ready_i) |=> (state_q == S_DONE))
    else $error("finished result lost while the receiver stalls");

endmodule

`default_nettype wire

// File: sv/outlier_rejecting_moving_average.sv
// ----------------------------------------------------------------------------
// outlier_rejecting_moving_average
// Trimmed moving average over a ring of signed samples, with the largest and
// smallest values replaced by the previous output before averaging.
// ----------------------------------------------------------------------------
// Usage:
// Samples arrive on sample_chan, one per transaction; each gives exactly one
// Q16.8 result on result_chan. Registers (window length, outlier rounds) are
// written through cfg_we_i / cfg_idx_i / cfg_wdata_i while the block is idle.
// One sample is processed at a time. The sum is 30 bits wide at a window
// of 32. The copy, each outlier search round and the sum each sweep the
// effective window through the single read port of the working copy, and
// the restoring divider then produces the quotient bit by bit. The next
// sample is accepted in the cycle after the result has been loaded.
// The result sits in an output register, so a stalled receiver does not
// hold up the next sample; a finished result waits only while the previous
// one is still untaken. Reset clears the ring through per-entry valid bits
// (no clearing pass), the previous output and the write position, and
// restores the registers to a window of 20 and 4 rounds.
// ----------------------------------------------------------------------------
`default_nettype none

module outlier_rejecting_moving_average #(
  parameter int MAX_WINDOW = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic [oma_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [oma_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  oma_sample_if.sink                           sample_chan,
  oma_result_if.source                         result_chan
);

  import oma_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer.
  oma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_chan.valid),
    .in_ready_o  (sample_chan.ready),
    .out_valid_o (result_chan.valid),
    .out_ready_i (result_chan.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Storage and arithmetic.
  oma_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .sample_i         (sample_chan.sample),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .filtered_value_o (result_chan.filtered_value)
  );

endmodule

`default_nettype wire
